// ===== rtl/core/rcf_pkg.sv =====
`default_nettype none

package rcf_pkg;

    // fixed field widths
    localparam int PIX_W    = 8;
    localparam int RGB_W    = 3 * PIX_W;
    localparam int DIM_W    = 12;
    localparam int ROW_W    = 12;
    localparam int KA_W     = 60;
    localparam int KB_W     = 48;
    localparam int CFG_W    = 60;
    localparam int CFG_IDX_W = 2;

    // kernel layout
    localparam int NUM_TAPS   = 9;
    localparam int TAPS_IN_A  = 5;
    localparam int FRAC_BITS  = 8;
    localparam int COEF_RESET = 26;

    // output queue depth in words
    localparam int OUT_DEPTH = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_A     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_B     = 2'd3;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] in_blue;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_red;
    } rcf_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
        logic             frame_end;
    } rcf_out_t;

    // per-word control carried from the counter stage into the datapath
    typedef struct packed {
        logic valid;
        logic wr;
        logic top_ok;
        logic mid_ok;
        logic emit;
        logic interior;
        logic last;
    } rcf_ctl_t;

    // every coefficient at its reset value, packed low first
    function automatic logic [63:0] coef_fill(input int cb, input int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++) begin
            if (i * cb < 64) begin
                r = r | (64'(COEF_RESET) << (i * cb));
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgb_conv3x3_filter.sv =====
`default_nettype none

// 3x3 convolution filter over a raster stream of BGR pixels. One word in and
// one word out per clock unless m_ready stalls: the per-pixel work is a short pipeline
// (counter stage, line store read and window shift, 27 products, sum and
// clamp) and the two line stores share one dual-port RAM with one read and
// one write each cycle. Results pass the counter stage and the window and product
// registers into the output queue; it holds eight words, so input is taken while results
// wait downstream. Interior pixels become the weighted sum of their 3x3
// neighbourhood (signed Q4.8 coefficients, column by column from the left),
// truncated and clamped to 0..255; border pixels pass through. Output runs
// one row plus one pixel behind the input, so a frame is closed with
// frame_width+1 flush words. The line stores are not cleared after reset;
// reads above the first rows are gated off, so no clearing pass is needed.
// Write configuration only while the block is idle.
module rgb_conv3x3_filter
    import rcf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int COEF_BITS = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rcf_in_t              s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rcf_out_t                  m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CNTW = $clog2(OUT_DEPTH + 1);

    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [KA_W-1:0]    kernel_a_reg;
    logic [KB_W-1:0]    kernel_b_reg;

    logic               accept;
    logic [AW-1:0]      rd_addr;
    rcf_ctl_t           a_ctl;
    logic [RGB_W-1:0]   a_pix;
    logic [AW-1:0]      a_addr;
    logic [2*RGB_W-1:0] store_rd;
    logic [RGB_W-1:0]   mid_gated;
    logic               store_we;
    logic [1:0]         pipe_pending;
    logic               res_valid;
    rcf_out_t           res_data;
    logic [CNTW-1:0]    fifo_count;
    logic [CNTW:0]      pending;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            kernel_a_reg     <= KA_W'(coef_fill(COEF_BITS, TAPS_IN_A));
            kernel_b_reg     <= KB_W'(coef_fill(COEF_BITS, NUM_TAPS - TAPS_IN_A));
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_KERNEL_A:     kernel_a_reg     <= cfg_data[KA_W-1:0];
                REG_KERNEL_B:     kernel_b_reg     <= cfg_data[KB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // take a word only when the queue has room for everything in flight
    assign pending = (CNTW + 1)'(fifo_count) + (CNTW + 1)'(a_ctl.valid && a_ctl.emit) +
                     (CNTW + 1)'(pipe_pending);
    assign s_ready = pending < (CNTW + 1)'(OUT_DEPTH);
    assign accept  = s_valid && s_ready;

    rcf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .s_data       (s_data),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .rd_addr      (rd_addr),
        .a_ctl        (a_ctl),
        .a_pix        (a_pix),
        .a_addr       (a_addr)
    );

    // upper store in the high half, lower store in the low half
    assign store_we = a_ctl.valid && a_ctl.wr;

    rcf_ram #(
        .WIDTH (2 * RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (a_addr),
        .wr_data ({mid_gated, a_pix}),
        .rd_addr (rd_addr),
        .rd_data (store_rd)
    );

    rcf_conv #(
        .COEF_BITS (COEF_BITS)
    ) u_conv (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .a_ctl        (a_ctl),
        .a_pix        (a_pix),
        .rd_upper     (store_rd[2*RGB_W-1:RGB_W]),
        .rd_lower     (store_rd[RGB_W-1:0]),
        .kernel_a     (kernel_a_reg),
        .kernel_b     (kernel_b_reg),
        .mid_gated    (mid_gated),
        .pipe_pending (pipe_pending),
        .res_valid    (res_valid),
        .res_data     (res_data)
    );

    rcf_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res_data),
        .pop        (m_ready),
        .head_valid (m_valid),
        .head_data  (m_data),
        .count      (fifo_count)
    );

`ifndef SYNTHESIS
    // the output queue never overruns
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_count <= CNTW'(OUT_DEPTH))
        else $error("output queue overrun");

    // a pixel read never hits the column being written back
    assert property (@(posedge aclk) disable iff (!aresetn)
        (store_we && accept && (s_data.action == ACT_PIXEL)) |-> (rd_addr != a_addr))
        else $error("line store read and write collide");

    // a result is never pushed into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (fifo_count == CNTW'(OUT_DEPTH))) |-> m_ready)
        else $error("result pushed into a full queue");

    // ready comes back straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rcf_ram.sv =====
`default_nettype none

module rcf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/rcf_ctrl.sv =====
`default_nettype none

module rcf_ctrl
    import rcf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire rcf_in_t          s_data,
    input  wire logic [DIM_W-1:0] frame_width,
    input  wire logic [DIM_W-1:0] frame_height,
    output logic      [AW-1:0]    rd_addr,
    output rcf_ctl_t              a_ctl,
    output logic      [RGB_W-1:0] a_pix,
    output logic      [AW-1:0]    a_addr
);

    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0]    w_use;
    logic [ROW_W-1:0] h_use;

    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic [CW-1:0]    col_cur;
    logic [ROW_W:0]   row_cur;
    logic [CW-1:0]    ocol_cur;
    logic [ROW_W-1:0] orow_cur;

    rcf_ctl_t         a_ctl_reg, ctl_next;
    logic [RGB_W-1:0] a_pix_reg, pix_next;
    logic [AW-1:0]    a_addr_reg;

    // limit the frame size to what the line stores hold, and to at least 3x3
    always_comb begin
        if (frame_width < DIM_W'(3)) begin
            w_use = CW'(3);
        end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
            w_use = CW'(MAX_WIDTH);
        end else begin
            w_use = CW'(frame_width);
        end
        h_use = (frame_height < DIM_W'(3)) ? ROW_W'(3) : frame_height;
    end

    // raster counters and border decisions for the word being accepted
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        ctl_next     = '0;
        col_cur      = in_col_reg;
        row_cur      = {1'b0, in_row_reg};
        ocol_cur     = out_col_reg;
        orow_cur     = out_row_reg;
        pix_next     = (s_data.action == ACT_PIXEL) ?
                       {s_data.in_red, s_data.in_green, s_data.in_blue} : '0;
        if (accept) begin
            if (s_data.action == ACT_PIXEL) begin
                if (in_col_reg >= w_use) begin
                    col_cur = '0;
                    row_cur = {1'b0, in_row_reg} + (ROW_W + 1)'(1);
                end
                // new frame after a complete one: drop what is pending
                if (row_cur >= {1'b0, h_use}) begin
                    col_cur  = '0;
                    row_cur  = '0;
                    ocol_cur = '0;
                    orow_cur = '0;
                end
                ctl_next.valid  = 1'b1;
                ctl_next.wr     = 1'b1;
                ctl_next.top_ok = row_cur >= (ROW_W + 1)'(2);
                ctl_next.mid_ok = row_cur != '0;
                ctl_next.emit   = (row_cur >= (ROW_W + 1)'(2)) ||
                                  ((row_cur == (ROW_W + 1)'(1)) && (col_cur != '0));
                if (({1'b0, col_cur} + (CW + 1)'(1)) >= {1'b0, w_use}) begin
                    in_col_next = '0;
                    in_row_next = ROW_W'(row_cur + (ROW_W + 1)'(1));
                end else begin
                    in_col_next = col_cur + CW'(1);
                    in_row_next = row_cur[ROW_W-1:0];
                end
            end else if (in_row_reg >= h_use) begin
                // flush tick: replay the stored rows, zero below
                ctl_next.valid  = 1'b1;
                ctl_next.top_ok = in_col_reg < w_use;
                ctl_next.mid_ok = in_col_reg < w_use;
                ctl_next.emit   = 1'b1;
                if (in_col_reg != CW'(MAX_WIDTH)) begin
                    in_col_next = in_col_reg + CW'(1);
                end
            end
            out_col_next = ocol_cur;
            out_row_next = orow_cur;
            if (ctl_next.emit) begin
                ctl_next.interior = (orow_cur != '0) &&
                    (({1'b0, orow_cur} + (ROW_W + 1)'(2)) <= {1'b0, h_use}) &&
                    (ocol_cur != '0) &&
                    (({1'b0, ocol_cur} + (CW + 1)'(2)) <= {1'b0, w_use});
                ctl_next.last = (({1'b0, orow_cur} + (ROW_W + 1)'(1)) >= {1'b0, h_use}) &&
                    (({1'b0, ocol_cur} + (CW + 1)'(1)) >= {1'b0, w_use});
                if (ctl_next.last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (({1'b0, ocol_cur} + (CW + 1)'(1)) >= {1'b0, w_use}) begin
                    out_col_next = '0;
                    out_row_next = orow_cur + ROW_W'(1);
                end else begin
                    out_col_next = ocol_cur + CW'(1);
                end
            end
        end
    end

    assign rd_addr = col_cur[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            a_ctl_reg   <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            a_ctl_reg   <= ctl_next;
        end
    end

    // word payload for the store and window stage
    always_ff @(posedge aclk) begin
        a_pix_reg  <= pix_next;
        a_addr_reg <= col_cur[AW-1:0];
    end

    assign a_ctl  = a_ctl_reg;
    assign a_pix  = a_pix_reg;
    assign a_addr = a_addr_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rcf_conv.sv =====
`default_nettype none

module rcf_conv
    import rcf_pkg::*;
#(
    parameter int COEF_BITS = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire rcf_ctl_t         a_ctl,
    input  wire logic [RGB_W-1:0] a_pix,
    input  wire logic [RGB_W-1:0] rd_upper,
    input  wire logic [RGB_W-1:0] rd_lower,
    input  wire logic [KA_W-1:0]  kernel_a,
    input  wire logic [KB_W-1:0]  kernel_b,
    output logic      [RGB_W-1:0] mid_gated,
    output logic      [1:0]       pipe_pending,
    output logic                  res_valid,
    output rcf_out_t              res_data
);

    localparam int PW = PIX_W + 1 + COEF_BITS;
    localparam int SW = PW + 4;

    logic [63+COEF_BITS:0]        ka_ext;
    logic [63+COEF_BITS:0]        kb_ext;
    logic signed [COEF_BITS-1:0]  coef [NUM_TAPS];

    logic [RGB_W-1:0]             top_gated;
    logic [RGB_W-1:0]             win_reg [NUM_TAPS];

    logic                         b_valid_reg, b_interior_reg, b_last_reg;

    logic signed [PW-1:0]         prod_next [3][NUM_TAPS];
    logic signed [PW-1:0]         prod_reg [3][NUM_TAPS];
    logic [RGB_W-1:0]             center_reg;
    logic                         c_valid_reg, c_interior_reg, c_last_reg;

    logic signed [SW-1:0]         sum [3];
    logic [SW-1:0]                shifted [3];
    logic [PIX_W-1:0]             sat [3];

    // coefficient fields; a field past bit 63 reads as zero
    assign ka_ext = (64 + COEF_BITS)'(kernel_a);
    assign kb_ext = (64 + COEF_BITS)'(kernel_b);

    always_comb begin
        for (int k = 0; k < TAPS_IN_A; k++) begin
            coef[k] = ka_ext[k * COEF_BITS +: COEF_BITS];
        end
        for (int k = TAPS_IN_A; k < NUM_TAPS; k++) begin
            coef[k] = kb_ext[(k - TAPS_IN_A) * COEF_BITS +: COEF_BITS];
        end
    end

    // rows above the top of the frame read as zero
    assign top_gated = a_ctl.top_ok ? rd_upper : '0;
    assign mid_gated = a_ctl.mid_ok ? rd_lower : '0;

    // window shift: new right column from the stores and the incoming pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                win_reg[k] <= '0;
            end
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ctl.valid) begin
                for (int k = 0; k < 6; k++) begin
                    win_reg[k] <= win_reg[k + 3];
                end
                win_reg[6] <= top_gated;
                win_reg[7] <= mid_gated;
                win_reg[8] <= a_pix;
            end
            b_valid_reg <= a_ctl.valid && a_ctl.emit;
        end
    end

    always_ff @(posedge aclk) begin
        b_interior_reg <= a_ctl.interior;
        b_last_reg     <= a_ctl.last;
    end

    // one product per tap and channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                prod_next[ch][k] = PW'(
                    $signed({{COEF_BITS{1'b0}}, 1'b0, win_reg[k][ch * PIX_W +: PIX_W]}) *
                    $signed({{(PIX_W + 1){coef[k][COEF_BITS-1]}}, coef[k]}));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg       <= prod_next;
        center_reg     <= win_reg[4];
        c_interior_reg <= b_interior_reg;
        c_last_reg     <= b_last_reg;
    end

    // sum, truncate and clamp to 0..255
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int k = 0; k < NUM_TAPS; k++) begin
                sum[ch] = sum[ch] + SW'(prod_reg[ch][k]);
            end
            shifted[ch] = SW'(sum[ch] >>> FRAC_BITS);
            if (sum[ch][SW-1]) begin
                sat[ch] = '0;
            end else if (shifted[ch] > SW'(255)) begin
                sat[ch] = '1;
            end else begin
                sat[ch] = shifted[ch][PIX_W-1:0];
            end
        end
    end

    assign res_valid          = c_valid_reg;
    assign res_data.out_blue  = c_interior_reg ? sat[0] : center_reg[0 +: PIX_W];
    assign res_data.out_green = c_interior_reg ? sat[1] : center_reg[PIX_W +: PIX_W];
    assign res_data.out_red   = c_interior_reg ? sat[2] : center_reg[2 * PIX_W +: PIX_W];
    assign res_data.frame_end = c_last_reg;

    assign pipe_pending = {1'b0, b_valid_reg} + {1'b0, c_valid_reg};

endmodule

`default_nettype wire

// ===== rtl/core/rcf_fifo.sv =====
`default_nettype none

module rcf_fifo
    import rcf_pkg::*;
#(
    parameter int DEPTH = 8,
    localparam int PTRW = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire rcf_out_t        push_data,
    input  wire logic            pop,
    output logic                 head_valid,
    output rcf_out_t             head_data,
    output logic      [CNTW-1:0] count
);

    rcf_out_t         mem [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (push && !do_pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_data  = mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire
